FILE: rtl/cfta_pkg.sv
`default_nettype none
package cfta_pkg;
  localparam int COMP_W = 16;
  localparam int MAG_W = COMP_W + 1;
  localparam int NUM_W = MAG_W + 1;
  localparam int Q_W = 17;
  localparam int SIZE_W = 13;
  localparam int MAX_DIM = 4096;
  localparam int OFS_W = 26;
  localparam int DIV_STAGES = 4;

  typedef enum logic [2:0] {
    FACE_PX = 3'd0,
    FACE_NX = 3'd1,
    FACE_PY = 3'd2,
    FACE_NY = 3'd3,
    FACE_PZ = 3'd4,
    FACE_NZ = 3'd5
  } face_t;

  localparam logic [0:0] REG_WIDTH = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/cubemap_face_texel_address.sv
// Cube map face select and texel address.
// Input channel: in_valid/in_stall with in_dir_x/y/z, signed Q1.14; y is
// negated internally before face selection.
// Output channel: out_valid/out_stall with face, texel column and row, the
// RGB byte offset (col + row*width)*3, and a zero-direction flag.
// Configuration: APB-style, face_width at 0x0, face_height at 0x4; write
// them only while no request is in flight.
// Throughput: one request per cycle while out_stall does not hold the pipe.
// Pipeline: one stage for face select, eight for the two restoring
// dividers (two or three quotient bits per stage for each of u and v,
// run side by side), then scale multiply and the offset multiply-add.
// Stall: the whole pipe holds when out_valid is high and out_stall is
// high; in_stall then rises and nothing is lost or repeated. Empty stages
// hold as well, so bubbles stay where they are.
// Reset: the pipe empties and both sizes return to 512.
`default_nettype none
module cubemap_face_texel_address (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic signed [cfta_pkg::COMP_W-1:0] in_dir_x,
  input  wire logic signed [cfta_pkg::COMP_W-1:0] in_dir_y,
  input  wire logic signed [cfta_pkg::COMP_W-1:0] in_dir_z,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [2:0]               out_face,
  output logic [11:0]              out_texel_col,
  output logic [11:0]              out_texel_row,
  output logic [25:0]              out_byte_offset,
  output logic                     out_zero_direction,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import cfta_pkg::*;

  localparam int NDS = 2 * DIV_STAGES;
  localparam int NST = NDS + 3;

  typedef struct packed {
    logic [2:0]        face;
    logic              zero;
    logic [NUM_W-1:0]  ru;
    logic [NUM_W-1:0]  rv;
    logic [Q_W-1:0]    qu;
    logic [Q_W-1:0]    qv;
    logic [NUM_W+Q_W-1:0] nu;
    logic [NUM_W+Q_W-1:0] nv;
    logic [MAG_W-1:0]  major;
  } div_t;

  logic [SIZE_W-1:0] width_r, height_r;
  logic [NST-1:0] vld_r;
  logic adv;

  assign pready = 1'b1;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= SIZE_W'(512);
      height_r <= SIZE_W'(512);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WIDTH) width_r <= pwdata[SIZE_W-1:0];
      else height_r <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIDTH) prdata[SIZE_W-1:0] = width_r;
    else prdata[SIZE_W-1:0] = height_r;
  end

  logic [SIZE_W-1:0] w_use, h_use;
  always_comb begin
    w_use = width_r;
    h_use = height_r;
    if (width_r == '0) w_use = SIZE_W'(1);
    else if (width_r > SIZE_W'(MAX_DIM)) w_use = SIZE_W'(MAX_DIM);
    if (height_r == '0) h_use = SIZE_W'(1);
    else if (height_r > SIZE_W'(MAX_DIM)) h_use = SIZE_W'(MAX_DIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NST-2:0], in_valid};
  end

  // stage 0: face select, numerators
  logic signed [MAG_W-1:0] x, y, z, ax, ay, az, uc, vc, mj;
  logic [NUM_W-1:0] su, sv;
  logic [2:0] fsel;
  div_t d0;
  always_comb begin
    x = MAG_W'(in_dir_x);
    y = -MAG_W'(in_dir_y);
    z = MAG_W'(in_dir_z);
    ax = x[MAG_W-1] ? -x : x;
    ay = y[MAG_W-1] ? -y : y;
    az = z[MAG_W-1] ? -z : z;
    mj = '0; uc = '0; vc = '0; fsel = FACE_PX;
    if (x > 0 && ax >= ay && ax >= az) begin mj = ax; uc = -z; vc = y; fsel = FACE_PX; end
    if (x <= 0 && ax >= ay && ax >= az) begin mj = ax; uc = z; vc = y; fsel = FACE_NX; end
    if (y > 0 && ay >= ax && ay >= az) begin mj = ay; uc = x; vc = -z; fsel = FACE_PY; end
    if (y <= 0 && ay >= ax && ay >= az) begin mj = ay; uc = x; vc = z; fsel = FACE_NY; end
    if (z > 0 && az >= ax && az >= ay) begin mj = az; uc = x; vc = y; fsel = FACE_PZ; end
    if (z <= 0 && az >= ax && az >= ay) begin mj = az; uc = -x; vc = y; fsel = FACE_NZ; end
    su = NUM_W'(uc + mj);
    sv = NUM_W'(vc + mj);
    d0 = '0;
    d0.zero = (x == 0) && (y == 0) && (z == 0);
    d0.face = d0.zero ? FACE_PX : fsel;
    d0.major = d0.zero ? MAG_W'(1) : MAG_W'(mj);
    // numerator (c+major)*32768: its bits above the low Q_W are (c+major)/4,
    // always below major, so preload them as the remainder and shift the
    // low Q_W bits through the divider MSB first
    d0.ru = su >> 2;
    d0.rv = sv >> 2;
    d0.nu = {su[1:0], (NUM_W+Q_W-2)'(0)};
    d0.nv = {sv[1:0], (NUM_W+Q_W-2)'(0)};
  end

  div_t dv_r [NDS+1];
  always_ff @(posedge clk) if (adv) dv_r[0] <= d0;

  // restoring division, two or three quotient bits per stage
  for (genvar s = 0; s < NDS; s++) begin : g_div
    localparam int LO = (s * Q_W) / NDS;
    localparam int HI = ((s + 1) * Q_W) / NDS;
    div_t dn;
    always_comb begin
      logic [NUM_W:0] tu, tv;
      dn = dv_r[s];
      for (int b = LO; b < HI; b++) begin
        tu = {dn.ru, dn.nu[NUM_W+Q_W-1]};
        tv = {dn.rv, dn.nv[NUM_W+Q_W-1]};
        dn.nu = dn.nu << 1;
        dn.nv = dn.nv << 1;
        if (tu >= (NUM_W+1)'(dn.major)) begin
          tu = tu - (NUM_W+1)'(dn.major); dn.qu = {dn.qu[Q_W-2:0], 1'b1};
        end else dn.qu = {dn.qu[Q_W-2:0], 1'b0};
        if (tv >= (NUM_W+1)'(dn.major)) begin
          tv = tv - (NUM_W+1)'(dn.major); dn.qv = {dn.qv[Q_W-2:0], 1'b1};
        end else dn.qv = {dn.qv[Q_W-2:0], 1'b0};
        dn.ru = tu[NUM_W-1:0];
        dn.rv = tv[NUM_W-1:0];
      end
    end
    always_ff @(posedge clk) if (adv) dv_r[s+1] <= dn;
  end

  // quotient <= 65536 fits Q_W bits

  // scale stage
  div_t dq;
  assign dq = dv_r[NDS];
  logic [Q_W+SIZE_W-1:0] pc, pr;
  logic [SIZE_W-1:0] col_c, row_c;
  always_comb begin
    pc = Q_W'(dq.qu) * (Q_W+SIZE_W)'(w_use);
    pr = Q_W'(dq.qv) * (Q_W+SIZE_W)'(h_use);
    col_c = SIZE_W'(pc >> 16);
    row_c = SIZE_W'(pr >> 16);
    if (col_c > w_use - 1'b1) col_c = w_use - 1'b1;
    if (row_c > h_use - 1'b1) row_c = h_use - 1'b1;
  end

  logic [2:0] f1_r;
  logic z1_r;
  logic [11:0] c1_r, r1_r;
  always_ff @(posedge clk) if (adv) begin
    f1_r <= dq.face;
    z1_r <= dq.zero;
    c1_r <= dq.zero ? 12'd0 : col_c[11:0];
    r1_r <= dq.zero ? 12'd0 : row_c[11:0];
  end

  logic [OFS_W+1:0] lin;
  assign lin = (OFS_W+2)'(c1_r) + (OFS_W+2)'(r1_r) * (OFS_W+2)'(w_use);
  always_ff @(posedge clk) if (adv) begin
    out_face <= f1_r;
    out_zero_direction <= z1_r;
    out_texel_col <= c1_r;
    out_texel_row <= r1_r;
    out_byte_offset <= OFS_W'(lin * (OFS_W+2)'(3));
  end
endmodule
`default_nettype wire

FILE: rtl/cfta_checker.sv
`default_nettype none
module cfta_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [2:0] out_face,
  input wire logic [11:0] out_texel_col,
  input wire logic [25:0] out_byte_offset,
  input wire logic out_zero_direction
);
  import cfta_pkg::*;

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall)) else $error("stall mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_offset))
    else $error("result dropped");
  a_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_face <= FACE_NZ) else $error("bad face");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_direction |-> out_face == FACE_PX &&
      out_texel_col == 12'd0 && out_byte_offset == 26'd0)
    else $error("zero direction not clean");
endmodule
bind cubemap_face_texel_address cfta_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_face(out_face),
  .out_texel_col(out_texel_col), .out_byte_offset(out_byte_offset),
  .out_zero_direction(out_zero_direction));
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cfta_pkg::*;

  typedef struct {
    face_t       face;
    logic [11:0] col;
    logic [11:0] row;
    logic [25:0] ofs;
    logic        zero;
  } texel_addr_t;

  class texel_scoreboard;
    texel_addr_t pending[$];
    int          errors;
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    function new();
      errors = 0;
      width_reg = 13'd512;
      height_reg = 13'd512;
    endfunction

    function longint clamp_size(logic [12:0] r);
      if (r == 0) return 1;
      if (r > MAX_DIM) return MAX_DIM;
      return r;
    endfunction

    function longint texel_of(longint c, longint major, longint size);
      longint unit16;
      longint t;
      unit16 = ((c + major) * 32768) / major;
      t = (unit16 * size) >>> 16;
      if (t > size - 1) t = size - 1;
      return t;
    endfunction

    function void note_request(logic signed [15:0] dx, logic signed [15:0] dy,
                               logic signed [15:0] dz);
      texel_addr_t e;
      longint x, y, z, ax, ay, az, major, uc, vc, w, h, col, row;
      x = dx;
      y = -longint'(dy);
      z = dz;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      major = 1; uc = 0; vc = 0;
      e.face = FACE_PX;
      e.zero = 1'b0;
      if (x == 0 && y == 0 && z == 0) begin
        e.col = 0; e.row = 0; e.ofs = 0; e.zero = 1'b1;
        pending = {pending, e};
        return;
      end
      // later faces win ties
      if (x > 0 && ax >= ay && ax >= az) begin
        major = ax; uc = -z; vc = y; e.face = FACE_PX;
      end
      if (x <= 0 && ax >= ay && ax >= az) begin
        major = ax; uc = z; vc = y; e.face = FACE_NX;
      end
      if (y > 0 && ay >= ax && ay >= az) begin
        major = ay; uc = x; vc = -z; e.face = FACE_PY;
      end
      if (y <= 0 && ay >= ax && ay >= az) begin
        major = ay; uc = x; vc = z; e.face = FACE_NY;
      end
      if (z > 0 && az >= ax && az >= ay) begin
        major = az; uc = x; vc = y; e.face = FACE_PZ;
      end
      if (z <= 0 && az >= ax && az >= ay) begin
        major = az; uc = -x; vc = y; e.face = FACE_NZ;
      end
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      col = texel_of(uc, major, w);
      row = texel_of(vc, major, h);
      e.col = col[11:0];
      e.row = row[11:0];
      e.ofs = 26'((col + row * w) * 3);
      pending = {pending, e};
    endfunction

    function void check_result(logic [2:0] face, logic [11:0] col, logic [11:0] row,
                               logic [25:0] ofs, logic zero);
      texel_addr_t e;
      if (pending.size() == 0) begin
        $error("unexpected result face=%0d col=%0d row=%0d", face, col, row);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (face !== e.face) begin
        $error("face: expected %0d, got %0d", e.face, face); errors++;
      end
      if (col !== e.col) begin
        $error("texel_col: expected %0d, got %0d", e.col, col); errors++;
      end
      if (row !== e.row) begin
        $error("texel_row: expected %0d, got %0d", e.row, row); errors++;
      end
      if (ofs !== e.ofs) begin
        $error("byte_offset: expected %0d, got %0d", e.ofs, ofs); errors++;
      end
      if (zero !== e.zero) begin
        $error("zero_direction: expected %0d, got %0d", e.zero, zero); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_face;
  logic [11:0] out_texel_col, out_texel_row;
  logic [25:0] out_byte_offset;
  logic out_zero_direction;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  texel_scoreboard board = new();
  bit quiet_tail = 1'b0;
  bit sink_idle_on = 1'b1;

  cubemap_face_texel_address DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_dir_x, .in_dir_y, .in_dir_z,
    .out_valid, .out_stall, .out_face, .out_texel_col, .out_texel_row,
    .out_byte_offset, .out_zero_direction,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // sample both channels at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      board.note_request(in_dir_x, in_dir_y, in_dir_z);
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_face, out_texel_col, out_texel_row, out_byte_offset,
                         out_zero_direction);
  end

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet_tail && sink_idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic write_size(logic [0:0] idx, logic [31:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_WIDTH) board.width_reg = val[12:0];
    else board.height_reg = val[12:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_dir(logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] z);
    int n;
    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_dir_x <= x;
    in_dir_y <= y;
    in_dir_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_dirs(int count);
    logic [15:0] a, b, c;
    repeat (count) begin
      a = rand_comp(); b = rand_comp(); c = rand_comp();
      // ties on magnitude
      if ($urandom_range(0, 7) == 0) b = ($urandom_range(0, 1)) ? a : -a;
      if ($urandom_range(0, 7) == 0) c = ($urandom_range(0, 1)) ? a : -a;
      send_dir(a, b, c);
    end
  endtask

  initial begin
    logic [12:0] sizes[8];
    sizes = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd3,
              13'd640, 13'd2048};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed with reset sizes
    send_dir(16'sd0, 16'sd0, 16'sd0);
    send_dir(16'sd16384, 16'sd0, 16'sd0);
    send_dir(-16'sd16384, 16'sd0, 16'sd0);
    send_dir(16'sd0, -16'sd16384, 16'sd0);
    send_dir(16'sd0, 16'sd16384, 16'sd0);
    send_dir(16'sd0, 16'sd0, 16'sd16384);
    send_dir(16'sd0, 16'sd0, -16'sd16384);
    send_dir(16'sh8000, 16'sh8000, 16'sh8000);
    send_dir(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_dir(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_dir(16'sd0, 16'sh8000, 16'sd0);
    send_dir(16'sd100, -16'sd100, 16'sd100);
    send_dir(-16'sd5, 16'sd5, -16'sd5);
    send_dir(16'sd1, 16'sd0, 16'sd0);
    send_dir(16'sd1, 16'sd0, -16'sd1);
    send_dir(16'sd0, 16'sd0, -16'sd1);
    send_dir(16'sh7FFF, -16'sd32767, -16'sd32767);
    send_dir(16'shFFFF, 16'sh0000, 16'sh0001);
    drain();
    foreach (sizes[i]) begin
      write_size(REG_WIDTH, {19'd0, sizes[i]});
      write_size(REG_HEIGHT, {19'd0, sizes[(i + 3) % 8]});
      @(posedge clk);
      send_dir(16'sd16384, -16'sd16384, 16'sd16384);
      send_dir(16'sd16384, 16'sd16384, -16'sd16384);
      random_dirs(180);
      if (i == 7) begin
        quiet_tail = 1'b1;
        sink_idle_on = 1'b0;
        random_dirs(80);
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
`default_nettype wire
